@@ sv/lat_pkg.sv @@
package lat_pkg;

	// table geometry and field widths
	localparam int ENTRIES_DEF = 5;
	localparam int ADDR_W      = 32;
	localparam int TIME_W      = 32;
	localparam int OCC_W       = 3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_CMP,
		ST_APPEND,
		ST_COMMIT
	} state_t;

endpackage

@@ sv/lat_if.sv @@
// request word: address and current time
interface lat_in_if;
	logic                        valid;
	logic                        ready;
	logic [lat_pkg::ADDR_W-1:0]  peer_addr;
	logic [lat_pkg::TIME_W-1:0]  now_time;

	modport source (output valid, output peer_addr, output now_time, input ready);
	modport sink   (input valid, input peer_addr, input now_time, output ready);
endinterface

// response word: status and occupancy
interface lat_out_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [lat_pkg::OCC_W-1:0]   occupancy;

	modport source (output valid, output status, output occupancy, input ready);
	modport sink   (input valid, input status, input occupancy, output ready);
endinterface

@@ sv/lat_ram.sv @@
module lat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = lat_pkg::ENTRIES_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/lat_seq.sv @@
module lat_seq #(
	parameter int ENTRIES = lat_pkg::ENTRIES_DEF,
	localparam int POS_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lat_in_if.sink                     req,
	lat_out_if.source                  rsp,
	// recency order memory
	output logic                       ord_we,
	output logic [POS_W-1:0]           ord_waddr,
	output logic [POS_W-1:0]           ord_wdata,
	output logic                       ord_re,
	output logic [POS_W-1:0]           ord_raddr,
	input  logic [POS_W-1:0]           ord_rdata,
	// address memory
	output logic                       adr_we,
	output logic [POS_W-1:0]           adr_waddr,
	output logic [lat_pkg::ADDR_W-1:0] adr_wdata,
	output logic                       adr_re,
	output logic [POS_W-1:0]           adr_raddr,
	input  logic [lat_pkg::ADDR_W-1:0] adr_rdata,
	// time stamp memory
	output logic                       seen_we,
	output logic [POS_W-1:0]           seen_waddr,
	output logic [lat_pkg::TIME_W-1:0] seen_wdata
);

	lat_pkg::state_t state_q, state_d;

	logic [POS_W-1:0]           pos_q;
	logic [CNT_W-1:0]           count_q;
	logic [POS_W-1:0]           carry_q;
	logic                       found_q;
	logic [lat_pkg::ADDR_W-1:0] addr_q;
	logic [lat_pkg::TIME_W-1:0] time_q;
	logic                       out_valid_q;
	logic                       status_q;
	logic [lat_pkg::OCC_W-1:0]  occ_q;

	logic             accept;
	logic             hit;
	logic             last_pos;
	logic             full;
	logic             out_free;
	logic             commit_go;
	logic             grow;
	logic [POS_W-1:0] slot_sel;
	logic [CNT_W-1:0] count_next;

	// status terms
	assign accept     = req.valid && req.ready;
	assign hit        = (adr_rdata == addr_q);
	assign last_pos   = ((CNT_W'(pos_q) + CNT_W'(1)) == count_q);
	assign full       = (count_q == CNT_W'(ENTRIES));
	assign out_free   = !out_valid_q || rsp.ready;
	assign commit_go  = (state_q == lat_pkg::ST_COMMIT) && out_free;
	assign grow       = !found_q && !full;
	assign count_next = grow ? count_q + CNT_W'(1) : count_q;
	// hit or full miss reuse the carried slot, otherwise the next free one
	assign slot_sel   = (found_q || full) ? carry_q : POS_W'(count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lat_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (count_q == '0) ? lat_pkg::ST_COMMIT : lat_pkg::ST_ADDR;
				end
			end
			lat_pkg::ST_ADDR: begin
				state_d = lat_pkg::ST_CMP;
			end
			lat_pkg::ST_CMP: begin
				if (hit) begin
					state_d = lat_pkg::ST_COMMIT;
				end else if (last_pos) begin
					state_d = full ? lat_pkg::ST_COMMIT : lat_pkg::ST_APPEND;
				end else begin
					state_d = lat_pkg::ST_ADDR;
				end
			end
			lat_pkg::ST_APPEND: begin
				state_d = lat_pkg::ST_COMMIT;
			end
			lat_pkg::ST_COMMIT: begin
				if (out_free) begin
					state_d = lat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lat_pkg::ST_IDLE;
			end
		endcase
	end

	// memory port controls
	always_comb begin
		req.ready  = 1'b0;
		ord_re     = 1'b0;
		ord_raddr  = '0;
		ord_we     = 1'b0;
		ord_waddr  = '0;
		ord_wdata  = carry_q;
		adr_re     = 1'b0;
		adr_raddr  = ord_rdata;
		adr_we     = 1'b0;
		adr_waddr  = slot_sel;
		adr_wdata  = addr_q;
		seen_we    = 1'b0;
		seen_waddr = slot_sel;
		seen_wdata = time_q;
		unique case (state_q)
			lat_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				ord_re    = 1'b1;
			end
			lat_pkg::ST_ADDR: begin
				// fetch the address, shift the order entry down by one
				adr_re    = 1'b1;
				ord_we    = (pos_q != '0);
				ord_waddr = pos_q;
			end
			lat_pkg::ST_CMP: begin
				ord_re    = !hit && !last_pos;
				ord_raddr = pos_q + POS_W'(1);
			end
			lat_pkg::ST_APPEND: begin
				ord_we    = 1'b1;
				ord_waddr = POS_W'(count_q);
			end
			lat_pkg::ST_COMMIT: begin
				ord_we    = out_free;
				ord_waddr = '0;
				ord_wdata = slot_sel;
				adr_we    = out_free;
				seen_we   = out_free;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lat_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_go) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= req.peer_addr;
			time_q  <= req.now_time;
			pos_q   <= '0;
			found_q <= 1'b0;
		end
		if (state_q == lat_pkg::ST_ADDR) begin
			carry_q <= ord_rdata;
		end
		if (state_q == lat_pkg::ST_CMP) begin
			if (hit) begin
				found_q <= 1'b1;
			end else if (!last_pos) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
		if (commit_go) begin
			status_q <= !found_q;
			occ_q    <= lat_pkg::OCC_W'(count_next);
		end
	end

	// response word
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	a_search_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lat_pkg::ST_ADDR || state_q == lat_pkg::ST_CMP)
		|-> (CNT_W'(pos_q) < count_q))
		else $error("search position beyond valid entries");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go && found_q |=> $stable(count_q))
		else $error("hit changed entry count");

	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go && !found_q && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert into non-full table did not grow count");

	a_commit_word: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> rsp.valid && (rsp.status == !$past(found_q)))
		else $error("response word not raised after commit");

endmodule

@@ sv/lru_address_table_unit.sv @@
// lru address table: recency-ordered table of ENTRIES 32-bit addresses
//
// req channel carries one word per lookup: peer_addr and now_time. a known
// address gets its time stamp refreshed and moves to the most recent place
// (status 0); an unknown one is inserted there (status 1), taking the next
// free slot or, with the table full, the slot of the least recent entry.
// rsp channel returns one word per request: status and the occupancy after
// the step (count masked to 3 bits).
//
// the table lives in three synchronous memories (recency order, address,
// time stamp). each compared position takes an order read, then an address
// read and compare, with the order entry shifted down on the way. a new
// address that fills a free slot takes an extra append step before the
// commit step; an empty table goes straight to commit. one request is in
// flight at a time.
//
// reset empties the table (count cleared, memories left as they are).
// a finished response waits in an output register; the next request is
// taken meanwhile, and is held before its commit step while rsp stalls.
module lru_address_table_unit #(
	parameter int ENTRIES = lat_pkg::ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lat_in_if.sink    req,
	lat_out_if.source rsp
);

	localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic                       ord_we, ord_re;
	logic [POS_W-1:0]           ord_waddr, ord_wdata, ord_raddr, ord_rdata;
	logic                       adr_we, adr_re;
	logic [POS_W-1:0]           adr_waddr, adr_raddr;
	logic [lat_pkg::ADDR_W-1:0] adr_wdata, adr_rdata;
	logic                       seen_we;
	logic [POS_W-1:0]           seen_waddr;
	logic [lat_pkg::TIME_W-1:0] seen_wdata;

	// sequencer
	lat_seq #(.ENTRIES(ENTRIES)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.ord_we     (ord_we),
		.ord_waddr  (ord_waddr),
		.ord_wdata  (ord_wdata),
		.ord_re     (ord_re),
		.ord_raddr  (ord_raddr),
		.ord_rdata  (ord_rdata),
		.adr_we     (adr_we),
		.adr_waddr  (adr_waddr),
		.adr_wdata  (adr_wdata),
		.adr_re     (adr_re),
		.adr_raddr  (adr_raddr),
		.adr_rdata  (adr_rdata),
		.seen_we    (seen_we),
		.seen_waddr (seen_waddr),
		.seen_wdata (seen_wdata)
	);

	// recency order: slot numbers by position
	lat_ram #(.WIDTH(POS_W), .DEPTH(ENTRIES)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.re    (ord_re),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	// stored addresses by slot
	lat_ram #(.WIDTH(lat_pkg::ADDR_W), .DEPTH(ENTRIES)) u_adr_ram (
		.clk   (clk),
		.we    (adr_we),
		.waddr (adr_waddr),
		.wdata (adr_wdata),
		.re    (adr_re),
		.raddr (adr_raddr),
		.rdata (adr_rdata)
	);

	// last-seen stamps by slot, write only
	lat_ram #(.WIDTH(lat_pkg::TIME_W), .DEPTH(ENTRIES)) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.re    (1'b0),
		.raddr (seen_waddr),
		.rdata ()
	);

endmodule
